// ----- hw/rtl/rba_pkg.sv -----
// shared types and constants of the ring buffer allocator
`default_nettype none

package rba_pkg;

    localparam int BUF_BYTES_DEF    = 4096;
    localparam int HEADER_BYTES_DEF = 8;

    localparam int POS_W = 12;

    typedef enum logic [1:0] {
        ST_ALLOC     = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SPACE  = 2'd2,
        ST_RELEASED  = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   data_pos;
    } t_result;

    typedef struct packed {
        logic we_flag;
        logic we_size;
        logic wflag;
        logic re;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RMOD,
        S_EVAL,
        S_WALK,
        S_HDR,
        S_FIN,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/rba_hdr_mem.sv -----
// header store: allocated flags and entry sizes, one read port and one write port
`default_nettype none

module rba_hdr_mem #(
    parameter int BUF_BYTES = rba_pkg::BUF_BYTES_DEF
) (
    input  wire                             i_clk,
    input  wire  rba_pkg::t_mem_ctl         i_ctl,
    input  wire  [$clog2(BUF_BYTES)-1:0]    i_waddr,
    input  wire  [$clog2(BUF_BYTES+1)-1:0]  i_wsize,
    input  wire  [$clog2(BUF_BYTES)-1:0]    i_raddr,
    output logic                            o_rflag,
    output logic [$clog2(BUF_BYTES+1)-1:0]  o_rsize
);

    localparam int SW = $clog2(BUF_BYTES + 1);

    logic          r_flag_mem [BUF_BYTES];
    logic [SW-1:0] r_size_mem [BUF_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_flag) begin
            r_flag_mem[i_waddr] <= i_ctl.wflag;
        end
        if (i_ctl.re) begin
            o_rflag <= r_flag_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_size) begin
            r_size_mem[i_waddr] <= i_wsize;
        end
        if (i_ctl.re) begin
            o_rsize <= r_size_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rba_out.sv -----
// result output register, frees the controller while a beat waits downstream
`default_nettype none

module rba_out (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_res_valid,
    input  wire rba_pkg::t_result i_res,
    output logic             o_res_ready,
    output logic             o_m_axis_tvalid,
    input  wire              i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata
);

    logic             r_valid;
    rba_pkg::t_result r_res;

    assign o_res_ready = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {2'b00, r_res.data_pos, r_res.status};

endmodule

`default_nettype wire

// ----- hw/rtl/rba_ctrl.sv -----
// allocator sequencer: request decode, wraparound, reclaim walk, header updates
`default_nettype none

module rba_ctrl #(
    parameter int BUF_BYTES    = rba_pkg::BUF_BYTES_DEF,
    parameter int HEADER_BYTES = rba_pkg::HEADER_BYTES_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_req_valid,
    output logic                            o_req_ready,
    input  wire                             i_req_type,
    input  wire  [15:0]                     i_request_size,
    input  wire  [11:0]                     i_release_pos,
    output rba_pkg::t_mem_ctl               o_mem_ctl,
    output logic [$clog2(BUF_BYTES)-1:0]    o_waddr,
    output logic [$clog2(BUF_BYTES+1)-1:0]  o_wsize,
    output logic [$clog2(BUF_BYTES)-1:0]    o_raddr,
    input  wire                             i_rflag,
    input  wire  [$clog2(BUF_BYTES+1)-1:0]  i_rsize,
    output logic                            o_res_valid,
    output rba_pkg::t_result                o_res,
    input  wire                             i_res_ready
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int PW = $clog2(BUF_BYTES + 1);
    localparam int WW = (PW + 2 > 18) ? PW + 2 : 18;
    // reciprocal fold of a 12-bit release position into the buffer
    localparam int FOLD = (BUF_BYTES > 4095) ? 0 : 1;
    localparam int RSH  = (FOLD > 0) ? 12 + $clog2(BUF_BYTES) : 0;
    localparam longint RMUL = (FOLD > 0) ?
        ((longint'(1) << RSH) + longint'(BUF_BYTES) - 1) / longint'(BUF_BYTES) : 0;

    localparam logic [WW-1:0] BUF_W = WW'(BUF_BYTES);
    localparam logic [WW-1:0] HDR_W = WW'(HEADER_BYTES);
    localparam logic [PW-1:0] BUF_P = PW'(BUF_BYTES);

    rba_pkg::t_state  r_state, n_state;
    logic             r_kind, n_kind;
    logic [WW-1:0]    r_real, n_real;
    logic [11:0]      r_rel, n_rel;
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_free, n_free;
    logic [PW-1:0]    r_left, n_left;
    rba_pkg::t_result r_res, n_res;

    logic [WW-1:0] head_w, free_w, left_w, size_w, end_w, end_mod;
    logic [WW-1:0] head_eff, free_eff, rel_p, rel_idx, fill_w;
    logic [25:0]   fold_prod;
    logic [23:0]   fold_back;
    logic          wrap, done;
    rba_pkg::t_result res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rba_pkg::S_IDLE;
            r_head  <= '0;
            r_free  <= BUF_P;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_real <= n_real;
        r_rel  <= n_rel;
        r_res  <= n_res;
    end

    always_comb begin
        head_w    = WW'(r_head);
        free_w    = WW'(r_free);
        left_w    = WW'(r_left);
        size_w    = WW'(i_rsize);
        end_w     = head_w + free_w;
        end_mod   = (end_w >= BUF_W) ? end_w - BUF_W : end_w;
        fill_w    = free_w + left_w;
        fold_prod = 26'(r_rel) * 26'(RMUL);
        fold_back = 24'(fold_prod >> RSH) * 24'(BUF_BYTES);
        rel_p     = WW'(r_rel);
        rel_idx   = (rel_p >= HDR_W) ? rel_p - HDR_W : rel_p + BUF_W - HDR_W;
        wrap      = (r_state == rba_pkg::S_EVAL) && (head_w + r_real > BUF_W);
        head_eff  = wrap ? '0 : head_w;
        free_eff  = wrap ? '0 : free_w;

        n_state = r_state;
        n_kind  = r_kind;
        n_real  = r_real;
        n_rel   = r_rel;
        n_head  = r_head;
        n_free  = r_free;
        n_left  = r_left;
        n_res   = r_res;

        o_req_ready = 1'b0;
        o_mem_ctl   = '0;
        o_waddr     = AW'(head_eff);
        o_wsize     = PW'(r_real);
        o_raddr     = AW'(end_mod);
        done        = 1'b0;
        res.status   = rba_pkg::ST_ALLOC;
        res.data_pos = '0;

        case (r_state)
            rba_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_kind = i_req_type;
                    n_real = WW'(i_request_size) + HDR_W;
                    n_rel  = i_release_pos;
                    n_state = (i_req_type && FOLD > 0) ? rba_pkg::S_RMOD
                                                       : rba_pkg::S_EVAL;
                end
            end
            rba_pkg::S_RMOD: begin
                n_rel   = r_rel - fold_back[11:0];
                n_state = rba_pkg::S_EVAL;
            end
            rba_pkg::S_EVAL, rba_pkg::S_FIN: begin
                if (r_kind) begin
                    o_mem_ctl.we_flag = 1'b1;
                    o_mem_ctl.wflag   = 1'b0;
                    o_waddr           = AW'(rel_idx);
                    res.status        = rba_pkg::ST_RELEASED;
                    done              = 1'b1;
                end else if (r_real > BUF_W) begin
                    res.status = rba_pkg::ST_TOO_LARGE;
                    done       = 1'b1;
                end else if (r_real <= free_eff) begin
                    o_mem_ctl.we_flag = 1'b1;
                    o_mem_ctl.we_size = 1'b1;
                    o_mem_ctl.wflag   = 1'b1;
                    n_head       = PW'(head_eff + r_real);
                    n_free       = PW'(free_eff - r_real);
                    res.data_pos = 12'((head_eff + HDR_W) & WW'(12'hFFF));
                    done         = 1'b1;
                end else if (r_state == rba_pkg::S_FIN) begin
                    res.status = rba_pkg::ST_NO_SPACE;
                    done       = 1'b1;
                end else begin
                    // wraparound takes effect even if the walk then comes up short
                    if (wrap) begin
                        n_left = r_free;
                        n_head = '0;
                        n_free = '0;
                    end
                    n_state = rba_pkg::S_WALK;
                end
            end
            rba_pkg::S_WALK: begin
                if (free_w >= BUF_W) begin
                    n_state = rba_pkg::S_FIN;
                end else if (r_left != '0 && end_w <= BUF_W && BUF_W - end_w == left_w) begin
                    // walk reached the bytes left unused at the last wraparound
                    n_free = (fill_w > BUF_W) ? BUF_P : PW'(fill_w);
                    n_left = '0;
                end else begin
                    o_mem_ctl.re = 1'b1;
                    n_state      = rba_pkg::S_HDR;
                end
            end
            rba_pkg::S_HDR: begin
                if (i_rflag || i_rsize == '0) begin
                    n_state = rba_pkg::S_FIN;
                end else begin
                    n_free  = (size_w >= BUF_W - free_w) ? BUF_P : PW'(free_w + size_w);
                    n_state = rba_pkg::S_WALK;
                end
            end
            rba_pkg::S_OUT: begin
                if (i_res_ready) begin
                    n_state = rba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rba_pkg::S_IDLE;
            end
        endcase

        if (done) begin
            n_res   = res;
            n_state = i_res_ready ? rba_pkg::S_IDLE : rba_pkg::S_OUT;
        end

        o_res_valid = done || (r_state == rba_pkg::S_OUT);
        o_res       = (r_state == rba_pkg::S_OUT) ? r_res : res;
    end

`ifndef NO_ASSERTIONS
    a_read_then_inspect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rba_pkg::S_WALK && o_mem_ctl.re) |=> (r_state == rba_pkg::S_HDR))
        else $error("header read not followed by inspection");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= BUF_P)
        else $error("free byte count beyond buffer size");
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= BUF_P)
        else $error("head offset beyond buffer size");
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.re && (o_mem_ctl.we_flag || o_mem_ctl.we_size)))
        else $error("header read and write in the same cycle");
    a_release_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && res.status == rba_pkg::ST_RELEASED) |-> r_kind)
        else $error("release status for an allocate request");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ring_buffer_allocator.sv -----
// Ring buffer allocator: linear allocation over a circular byte buffer with a header per
// entry. One result beat per request beat. An allocate or a release is accepted in S_IDLE,
// then decided in S_EVAL, which also writes the header store. For BUF_BYTES below 4096 a
// release first passes S_RMOD, which folds the 12-bit position into the buffer by a
// reciprocal multiplication. An allocate that runs short of space starts a reclaim walk:
// S_WALK issues each header read and S_HDR inspects the registered result, S_WALK absorbs
// the wraparound leftover, a walk that leaves the whole buffer free is seen in S_WALK, and
// S_FIN makes the final decision. The output register lets the next request enter while a
// result beat waits. The header store has no reset and needs no clearing pass.
`default_nettype none

module ring_buffer_allocator #(
    parameter int BUF_BYTES    = rba_pkg::BUF_BYTES_DEF,
    parameter int HEADER_BYTES = rba_pkg::HEADER_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [31:0] i_s_axis_tdata,  // request_size[15:0], release_pos[27:16], zero pad
    input  wire         i_s_axis_tuser,  // req_type
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata   // status[1:0], data_pos[13:2], zero pad
);

    localparam int AW = $clog2(BUF_BYTES);
    localparam int PW = $clog2(BUF_BYTES + 1);

    rba_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0]     waddr, raddr;
    logic [PW-1:0]     wsize, rsize;
    logic              rflag;
    logic              res_valid, res_ready;
    rba_pkg::t_result  res;

    rba_ctrl #(
        .BUF_BYTES    (BUF_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_s_axis_tvalid),
        .o_req_ready    (o_s_axis_tready),
        .i_req_type     (i_s_axis_tuser),
        .i_request_size (i_s_axis_tdata[15:0]),
        .i_release_pos  (i_s_axis_tdata[27:16]),
        .o_mem_ctl      (mem_ctl),
        .o_waddr        (waddr),
        .o_wsize        (wsize),
        .o_raddr        (raddr),
        .i_rflag        (rflag),
        .i_rsize        (rsize),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_ready    (res_ready)
    );

    rba_hdr_mem #(
        .BUF_BYTES (BUF_BYTES)
    ) u_hdr_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wsize (wsize),
        .i_raddr (raddr),
        .o_rflag (rflag),
        .o_rsize (rsize)
    );

    rba_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (res_valid),
        .i_res           (res),
        .o_res_ready     (res_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- bench/ring_buffer_allocator_tb.sv -----
// self-checking stream testbench of the ring buffer allocator
`timescale 1ns / 100ps

module ring_buffer_allocator_tb;

    localparam int BUF          = rba_pkg::BUF_BYTES_DEF;
    localparam int HDR          = rba_pkg::HEADER_BYTES_DEF;
    localparam int PLAN_MODEL   = 0;
    localparam int CHECK_MODEL  = 1;
    localparam int RANDOM_ITEMS = 475;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_LEN     = 400;
    localparam int CALM_FROM    = 250;
    localparam int CALM_TO      = 330;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind   kind;
        logic [15:0] size;
        logic [11:0] rel_pos;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [31:0] i_s_axis_tdata = '0;   // request_size[15:0], release_pos[27:16], zero pad
    logic        i_s_axis_tuser = 1'b0; // req_type
    logic        i_m_axis_tready = 1'b0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [15:0] o_m_axis_tdata;        // status[1:0], data_pos[13:2], zero pad

    ring_buffer_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // two copies of the allocator state: one steers stimulus, one checks the block
    logic [12:0] alloc_head [2];
    logic [12:0] alloc_free [2];
    logic [12:0] alloc_left [2];
    bit          hdr_flag   [2][BUF];
    logic [12:0] hdr_size   [2][BUF];
    bit          hdr_known  [2][BUF];

    t_req             item_q[$];
    rba_pkg::t_result pending_results[$];
    logic [11:0]      live_pos[$];
    t_req             cur_req;
    int          beats_in = 0;
    int          errors = 0;
    int          quiet = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    wire calm_window = (beats_in >= CALM_FROM) && (beats_in < CALM_TO);

    // reclaim walk over released headers that follow the free region
    function automatic bit walk_headers(input int m, inout int free_b, inout int left_b,
                                        input int head_b);
        int end_p;
        int idx;
        bit blocked;
        bit hit;
        blocked = 1'b0;
        hit = 1'b0;
        while (!blocked && free_b < BUF) begin
            end_p = head_b + free_b;
            if (left_b != 0 && end_p <= BUF && BUF - end_p == left_b) begin
                free_b = free_b + left_b;
                left_b = 0;
                if (free_b > BUF) free_b = BUF;
            end else begin
                idx = end_p % BUF;
                if (!hdr_known[m][idx]) begin
                    hit = 1'b1;
                    blocked = 1'b1;
                end else if (hdr_flag[m][idx] || hdr_size[m][idx] == 0) begin
                    blocked = 1'b1;
                end else if (hdr_size[m][idx] >= BUF - free_b) begin
                    free_b = BUF;
                end else begin
                    free_b = free_b + hdr_size[m][idx];
                end
            end
        end
        return hit;
    endfunction

    // one request against model m; state changes only when commit is set
    function automatic void serve_request(input int m, input t_req rq, input bit commit,
                                          output rba_pkg::t_status st,
                                          output logic [11:0] dpos, output bit hit);
        int real_sz;
        int head_b;
        int free_b;
        int left_b;
        int idx;
        hit = 1'b0;
        dpos = '0;
        if (rq.kind == REQ_RELEASE) begin
            idx = ((int'(rq.rel_pos) % BUF) + BUF - (HDR % BUF)) % BUF;
            if (commit) hdr_flag[m][idx] = 1'b0;
            st = rba_pkg::ST_RELEASED;
        end else begin
            real_sz = int'(rq.size) + HDR;
            if (real_sz > BUF) begin
                st = rba_pkg::ST_TOO_LARGE;
            end else begin
                head_b = alloc_head[m];
                free_b = alloc_free[m];
                left_b = alloc_left[m];
                // wrap stays in effect even if the request then fails
                if (head_b + real_sz > BUF) begin
                    left_b = free_b;
                    head_b = 0;
                    free_b = 0;
                end
                if (real_sz > free_b) hit = walk_headers(m, free_b, left_b, head_b);
                if (real_sz > free_b) begin
                    st = rba_pkg::ST_NO_SPACE;
                end else begin
                    st = rba_pkg::ST_ALLOC;
                    if (commit) begin
                        hdr_flag[m][head_b % BUF]  = 1'b1;
                        hdr_size[m][head_b % BUF]  = 13'(real_sz);
                        hdr_known[m][head_b % BUF] = 1'b1;
                    end
                    dpos = 12'(head_b + HDR);
                    head_b = head_b + real_sz;
                    free_b = free_b - real_sz;
                end
                if (commit) begin
                    alloc_head[m] = 13'(head_b);
                    alloc_free[m] = 13'(free_b);
                    alloc_left[m] = 13'(left_b);
                end
            end
        end
    endfunction

    function automatic t_req make_req(input t_req_kind kind, input logic [15:0] size,
                                      input logic [11:0] rel_pos);
        t_req rq;
        rq.kind = kind;
        rq.size = size;
        rq.rel_pos = rel_pos;
        return rq;
    endfunction

    // queue a request; an allocate whose walk would read a never-written header is swapped
    task automatic plan_item(input t_req rq);
        t_req use_rq;
        rba_pkg::t_status st;
        logic [11:0] dp;
        bit hit;
        int k;
        use_rq = rq;
        if (use_rq.kind == REQ_ALLOC) begin
            serve_request(PLAN_MODEL, use_rq, 1'b0, st, dp, hit);
            if (hit) begin
                if (live_pos.size() != 0) begin
                    use_rq.kind = REQ_RELEASE;
                    use_rq.rel_pos = live_pos[0];
                end else begin
                    use_rq.size = 16'hFFFF;
                end
            end
        end
        serve_request(PLAN_MODEL, use_rq, 1'b1, st, dp, hit);
        if (st == rba_pkg::ST_ALLOC) begin
            live_pos.push_back(dp);
        end else if (st == rba_pkg::ST_RELEASED) begin
            for (k = live_pos.size() - 1; k >= 0; k--)
                if (live_pos[k] == use_rq.rel_pos) live_pos.delete(k);
        end
        item_q.push_back(use_rq);
    endtask

    task automatic report_mismatch(input string msg);
        errors = errors + 1;
        if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task automatic check_result(input logic [15:0] beat);
        rba_pkg::t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing pending", beat));
        end else begin
            want = pending_results.pop_front();
            if (beat[1:0] !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", beat[1:0], want.status));
            if (beat[13:2] !== want.data_pos)
                report_mismatch($sformatf("data_pos %0d, wanted %0d", beat[13:2],
                                          want.data_pos));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        rba_pkg::t_status st;
        logic [11:0] dp;
        bit hit;
        rba_pkg::t_result r;
        bit rests;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                serve_request(CHECK_MODEL, cur_req, 1'b1, st, dp, hit);
                r.status = st;
                r.data_pos = dp;
                pending_results.push_back(r);
                beats_in <= beats_in + 1;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                rests = !(calm_window || hold_left != 0) && ($urandom_range(0, 99) < 21);
                if (item_q.size() != 0 && !rests) begin
                    cur_req = item_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {4'b0000, cur_req.rel_pos, cur_req.size};
                    i_s_axis_tuser  <= cur_req.kind;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge i_clk) begin : watch_results
        bit ready_next;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_result(o_m_axis_tdata);
            if (!hold_done && beats_in >= HOLD_AT) begin
                // long hold-off so the block fills up and stalls its input
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
                ready_next = 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                ready_next = (hold_left == 1);
            end else begin
                ready_next = calm_window || ($urandom_range(0, 99) >= 21);
            end
            i_m_axis_tready <= ready_next;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : run_test
        int n;
        int pick;
        logic [15:0] sz;
        alloc_head[PLAN_MODEL]  = '0;
        alloc_free[PLAN_MODEL]  = 13'(BUF);
        alloc_left[PLAN_MODEL]  = '0;
        alloc_head[CHECK_MODEL] = '0;
        alloc_free[CHECK_MODEL] = 13'(BUF);
        alloc_left[CHECK_MODEL] = '0;

        // size extremes, exact fill, wrap with leftovers, chained reclaim
        plan_item(make_req(REQ_ALLOC, 16'hFFFF, 12'd0));
        plan_item(make_req(REQ_ALLOC, 16'd4089, 12'd0));
        plan_item(make_req(REQ_ALLOC, 16'd4088, 12'd0));
        plan_item(make_req(REQ_ALLOC, 16'd0, 12'd0));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd8));
        plan_item(make_req(REQ_ALLOC, 16'd100, 12'd0));
        for (n = 0; n < 4; n++) plan_item(make_req(REQ_ALLOC, 16'd1000, 12'd0));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd8));
        plan_item(make_req(REQ_ALLOC, 16'd50, 12'd0));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd116));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd1124));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd2132));
        plan_item(make_req(REQ_ALLOC, 16'd3000, 12'd0));
        plan_item(make_req(REQ_ALLOC, 16'd1014, 12'd0));
        // zero payload right at the end reports a data position that wraps to 0
        plan_item(make_req(REQ_ALLOC, 16'd0, 12'd0));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd0));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd8));
        plan_item(make_req(REQ_RELEASE, 16'd0, 12'd8));
        plan_item(make_req(REQ_RELEASE, 16'hFFFF, 12'd4095));
        plan_item(make_req(REQ_ALLOC, 16'h5555, 12'hAAA));
        plan_item(make_req(REQ_ALLOC, 16'h0AAA, 12'h555));

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55 || (pick < 88 && live_pos.size() == 0)) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)      sz = 16'($urandom_range(0, 255));
                else if (pick < 95) sz = 16'($urandom_range(256, 2047));
                else                sz = 16'($urandom_range(2048, BUF - HDR));
                plan_item(make_req(REQ_ALLOC, sz, 12'($urandom_range(0, 4095))));
            end else if (pick < 88) begin
                // mostly oldest first so reclaim walks chain through several entries
                if ($urandom_range(0, 1) == 0)
                    plan_item(make_req(REQ_RELEASE, 16'($urandom), live_pos[0]));
                else
                    plan_item(make_req(REQ_RELEASE, 16'($urandom),
                                       live_pos[$urandom_range(0, live_pos.size() - 1)]));
            end else if (pick < 94) begin
                plan_item(make_req(REQ_RELEASE, 16'($urandom), 12'($urandom_range(0, 4095))));
            end else begin
                plan_item(make_req(REQ_ALLOC, 16'($urandom_range(BUF - HDR + 1, 65535)),
                                   12'($urandom_range(0, 4095))));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (item_q.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
